>>> rtl/arxpc_pkg.sv
package arxpc_pkg;

    localparam int unsigned WORD_W            = 32;
    localparam int unsigned WORDS             = 4;
    localparam int unsigned ROUND_COUNT_DEF   = 20;
    localparam int unsigned MIXES_PER_ROUND   = 4;
    localparam int unsigned APB_DATA_W        = 64;
    localparam int unsigned APB_ADDR_W        = 6;
    localparam int unsigned REG_IDX_W         = 3;

    // Register indexes (byte address = 8 * index)
    localparam logic [REG_IDX_W-1:0] REG_WHITEN_ENABLE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WHITEN_IN_LO  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WHITEN_IN_HI  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WHITEN_OUT_LO = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WHITEN_OUT_HI = 3'd4;

    // Rotation after each round, for b, c and d
    localparam int unsigned ROT_B = 8;
    localparam int unsigned ROT_C = 16;
    localparam int unsigned ROT_D = 24;

    typedef logic [WORDS-1:0][WORD_W-1:0] t_words;   // [0]=a .. [3]=d

    typedef struct packed {
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [WORD_W-1:0] word_c;
        logic [WORD_W-1:0] word_d;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] out_a;
        logic [WORD_W-1:0] out_b;
        logic [WORD_W-1:0] out_c;
        logic [WORD_W-1:0] out_d;
    } t_out_item;

    typedef struct packed {
        logic                  enable;
        logic [2*WORD_W-1:0]   in_lo;
        logic [2*WORD_W-1:0]   in_hi;
        logic [2*WORD_W-1:0]   out_lo;
        logic [2*WORD_W-1:0]   out_hi;
    } t_whiten_cfg;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                 input int unsigned r);
        return (x << r) | (x >> (WORD_W - r));
    endfunction

endpackage

>>> rtl/arxpc_regs.sv
module arxpc_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [arxpc_pkg::REG_IDX_W-1:0]     i_reg_idx,
    input  logic [arxpc_pkg::APB_DATA_W-1:0]    i_pwdata,
    output logic [arxpc_pkg::APB_DATA_W-1:0]    o_prdata,
    output arxpc_pkg::t_whiten_cfg              o_cfg
);
    import arxpc_pkg::*;

    t_whiten_cfg r_cfg;
    logic        wr_en;

    assign wr_en = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (i_reg_idx)
                REG_WHITEN_ENABLE: begin
                    r_cfg.enable <= i_pwdata[0];
                end
                REG_WHITEN_IN_LO: begin
                    r_cfg.in_lo <= i_pwdata;
                end
                REG_WHITEN_IN_HI: begin
                    r_cfg.in_hi <= i_pwdata;
                end
                REG_WHITEN_OUT_LO: begin
                    r_cfg.out_lo <= i_pwdata;
                end
                REG_WHITEN_OUT_HI: begin
                    r_cfg.out_hi <= i_pwdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (i_reg_idx)
            REG_WHITEN_ENABLE: o_prdata = {{(APB_DATA_W-1){1'b0}}, r_cfg.enable};
            REG_WHITEN_IN_LO:  o_prdata = r_cfg.in_lo;
            REG_WHITEN_IN_HI:  o_prdata = r_cfg.in_hi;
            REG_WHITEN_OUT_LO: o_prdata = r_cfg.out_lo;
            REG_WHITEN_OUT_HI: o_prdata = r_cfg.out_hi;
            default:           o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/arxpc_mix_stage.sv
module arxpc_mix_stage #(
    parameter int unsigned MIX_SEL = 0   // 0..3: which word this stage updates
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  arxpc_pkg::t_words   i_blk,
    output logic                o_valid,
    output arxpc_pkg::t_words   o_blk
);
    import arxpc_pkg::*;

    localparam logic [1:0] IDX_X = 2'(MIX_SEL);
    localparam logic [1:0] IDX_Y = 2'(MIX_SEL + 1);
    localparam logic [1:0] IDX_Z = 2'(MIX_SEL + 2);
    localparam logic [1:0] IDX_W = 2'(MIX_SEL + 3);
    localparam int unsigned ROT  = MIX_SEL + 1;
    localparam bit LAST_MIX      = (MIX_SEL == MIXES_PER_ROUND - 1);

    logic              r_valid;
    t_words            r_blk;
    t_words            n_blk;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] mixed;

    always_comb begin
        sum          = i_blk[IDX_X] + i_blk[IDX_Y];
        mixed        = (rotl32(sum, ROT) ^ i_blk[IDX_Z]) + i_blk[IDX_W];
        n_blk        = i_blk;
        n_blk[IDX_X] = mixed;
        // end of round: fixed word rotations
        if (LAST_MIX) begin
            n_blk[1] = rotl32(n_blk[1], ROT_B);
            n_blk[2] = rotl32(n_blk[2], ROT_C);
            n_blk[3] = rotl32(n_blk[3], ROT_D);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;

endmodule

>>> rtl/arx_permutation_cipher_128.sv
// ARX 128-bit permutation with optional key whitening, fully pipelined.
// A block is accepted on every cycle that start is high (busy is always
// low), and its result appears on o_result with o_done high for exactly
// one cycle. Throughput is one block per clock. The pipeline has one stage
// per mix step (four per round), plus an input whitening stage and an
// output whitening stage. The receiver cannot stall the pipeline: results
// must be taken when o_done is high.
// Whitening keys are read live from the register file, so registers are
// to be written only while no transaction is in flight.
module arx_permutation_cipher_128 #(
    parameter int unsigned ROUND_COUNT = arxpc_pkg::ROUND_COUNT_DEF   // 1..64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // command channel
    input  logic                                 start,
    output logic                                 busy,
    input  arxpc_pkg::t_in_item                  i_item,
    // result channel
    output logic                                 o_done,
    output arxpc_pkg::t_out_item                 o_result,
    // APB config port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [arxpc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [arxpc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [arxpc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);
    import arxpc_pkg::*;

    localparam int unsigned MIX_STAGES = MIXES_PER_ROUND * ROUND_COUNT;
    localparam int unsigned LATENCY    = MIX_STAGES + 2;

    t_whiten_cfg cfg;
    logic        accept;

    // stage 0: input whitening
    logic        r_s0_valid;
    t_words      r_s0_blk;
    t_words      n_s0_blk;
    t_words      in_key;

    // mix chain; index 0 is the stage-0 output
    logic   chain_valid [MIX_STAGES+1];
    t_words chain_blk   [MIX_STAGES+1];

    // output whitening stage
    logic      r_out_valid;
    t_out_item r_result;
    t_out_item n_result;
    t_words    out_key;
    t_words    last_blk;

    assign busy   = 1'b0;       // fully pipelined, never refuses
    assign pready = 1'b1;
    assign accept = start && !busy;

    arxpc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_reg_idx (paddr[APB_ADDR_W-1 -: REG_IDX_W]),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    // --- input whitening ---
    always_comb begin
        in_key[0] = cfg.in_lo[WORD_W-1:0];
        in_key[1] = cfg.in_lo[2*WORD_W-1:WORD_W];
        in_key[2] = cfg.in_hi[WORD_W-1:0];
        in_key[3] = cfg.in_hi[2*WORD_W-1:WORD_W];
        if (!cfg.enable) begin
            in_key = '0;
        end
        n_s0_blk[0] = i_item.word_a ^ in_key[0];
        n_s0_blk[1] = i_item.word_b ^ in_key[1];
        n_s0_blk[2] = i_item.word_c ^ in_key[2];
        n_s0_blk[3] = i_item.word_d ^ in_key[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_blk <= n_s0_blk;
    end

    assign chain_valid[0] = r_s0_valid;
    assign chain_blk[0]   = r_s0_blk;

    // --- round pipeline: one stage per mix step, rotations fold into the 4th ---
    for (genvar g = 0; g < MIX_STAGES; g++) begin : g_mix
        arxpc_mix_stage #(
            .MIX_SEL (g % MIXES_PER_ROUND)
        ) u_mix (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .i_blk   (chain_blk[g]),
            .o_valid (chain_valid[g+1]),
            .o_blk   (chain_blk[g+1])
        );
    end

    // --- output whitening ---
    always_comb begin
        last_blk   = chain_blk[MIX_STAGES];
        out_key[0] = cfg.out_lo[WORD_W-1:0];
        out_key[1] = cfg.out_lo[2*WORD_W-1:WORD_W];
        out_key[2] = cfg.out_hi[WORD_W-1:0];
        out_key[3] = cfg.out_hi[2*WORD_W-1:WORD_W];
        if (!cfg.enable) begin
            out_key = '0;
        end
        n_result.out_a = last_blk[0] ^ out_key[0];
        n_result.out_b = last_blk[1] ^ out_key[1];
        n_result.out_c = last_blk[2] ^ out_key[2];
        n_result.out_d = last_blk[3] ^ out_key[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= chain_valid[MIX_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_out_valid;
    assign o_result = r_result;

    // --- assertions ---

    // every result traces back to a transaction accepted at the pipeline input
    a_done_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LATENCY))
        else $error("result without matching transaction");

    // every accepted transaction yields a result
    a_accept_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_done)
        else $error("transaction lost in pipeline");

    // enable write lands in the register file on the next cycle
    a_enable_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && (paddr[APB_ADDR_W-1 -: REG_IDX_W] == REG_WHITEN_ENABLE))
        |=> (cfg.enable == $past(pwdata[0])))
        else $error("whiten_enable write not taken");

endmodule

>>> tb/tb_arx_permutation_cipher_128.sv
`timescale 1ns / 1ps

module tb_arx_permutation_cipher_128;
    import arxpc_pkg::*;

    localparam int unsigned ROUNDS      = ROUND_COUNT_DEF;
    // input whitening stage + one stage per mix + output whitening stage
    localparam int unsigned LATENCY     = 4 * ROUNDS + 2;
    localparam int unsigned PHASE_ITEMS = 256;
    // hang limit, with a wide margin over the length of the whole test
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_REPORTS = 10;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the whitening registers, computes the expected
    // permutation for every accepted block and matches results in order.
    // ------------------------------------------------------------------
    class arx_block_checker;
        logic        whiten_on;
        logic [63:0] key_in_lo;
        logic [63:0] key_in_hi;
        logic [63:0] key_out_lo;
        logic [63:0] key_out_hi;
        t_out_item   expected_blocks[$];
        int unsigned mismatches;

        function new();
            whiten_on  = 1'b0;
            key_in_lo  = '0;
            key_in_hi  = '0;
            key_out_lo = '0;
            key_out_hi = '0;
            mismatches = 0;
        endfunction

        // unused indexes fall through and change nothing
        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
            case (idx)
                REG_WHITEN_ENABLE: whiten_on  = value[0];
                REG_WHITEN_IN_LO:  key_in_lo  = value;
                REG_WHITEN_IN_HI:  key_in_hi  = value;
                REG_WHITEN_OUT_LO: key_out_lo = value;
                REG_WHITEN_OUT_HI: key_out_hi = value;
                default: ;
            endcase
        endfunction

        function logic [31:0] rot_left(logic [31:0] x, int unsigned r);
            logic [63:0] doubled;
            doubled = {x, x} << r;
            return doubled[63:32];
        endfunction

        function logic [31:0] mix_word(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                       logic [31:0] w, int unsigned r);
            logic [31:0] sum;
            sum = x + y;
            return (rot_left(sum, r) ^ z) + w;
        endfunction

        function t_out_item arx_permute(t_in_item blk);
            logic [31:0] a, b, c, d;
            t_out_item   res;
            a = blk.word_a;
            b = blk.word_b;
            c = blk.word_c;
            d = blk.word_d;
            if (whiten_on) begin
                a ^= key_in_lo[31:0];
                b ^= key_in_lo[63:32];
                c ^= key_in_hi[31:0];
                d ^= key_in_hi[63:32];
            end
            for (int i = 0; i < ROUNDS; i++) begin
                a = mix_word(a, b, c, d, 1);
                b = mix_word(b, c, d, a, 2);
                c = mix_word(c, d, a, b, 3);
                d = mix_word(d, a, b, c, 4);
                b = rot_left(b, ROT_B);
                c = rot_left(c, ROT_C);
                d = rot_left(d, ROT_D);
            end
            if (whiten_on) begin
                a ^= key_out_lo[31:0];
                b ^= key_out_lo[63:32];
                c ^= key_out_hi[31:0];
                d ^= key_out_hi[63:32];
            end
            res.out_a = a;
            res.out_b = b;
            res.out_c = c;
            res.out_d = d;
            return res;
        endfunction

        function void note_block(t_in_item blk);
            expected_blocks.push_back(arx_permute(blk));
        endfunction

        function void check_block(t_out_item got);
            t_out_item want;
            if (expected_blocks.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: a=%h b=%h c=%h d=%h",
                             got.out_a, got.out_b, got.out_c, got.out_d);
                mismatches++;
                return;
            end
            want = expected_blocks.pop_front();
            if (got.out_a !== want.out_a || got.out_b !== want.out_b ||
                got.out_c !== want.out_c || got.out_d !== want.out_d) begin
                if (mismatches < MAX_REPORTS)
                    $display("result mismatch: exp a=%h b=%h c=%h d=%h, got a=%h b=%h c=%h d=%h",
                             want.out_a, want.out_b, want.out_c, want.out_d,
                             got.out_a, got.out_b, got.out_c, got.out_d);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  start    = 1'b0;
    logic                  busy;
    t_in_item              i_item   = '0;
    logic                  o_done;
    t_out_item             o_result;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    arx_block_checker cipher_sb;
    int unsigned      elapsed_cycles;

    arx_permutation_cipher_128 #(
        .ROUND_COUNT(ROUNDS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, i.e. the values
    // the DUT itself sees. Inputs only move at the falling edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // register write completes on the access phase
            if (psel && penable && pwrite && pready)
                cipher_sb.write_reg(paddr[APB_ADDR_W-1:3], pwdata);
            // command transaction accepted
            if (start && !busy)
                cipher_sb.note_block(i_item);
            // result strobe, never held off by the receiver
            if (o_done)
                cipher_sb.check_block(o_result);
        end
    end

    // Hang guard: also catches results that never show up
    initial begin
        elapsed_cycles = 0;
        while (elapsed_cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            elapsed_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers. All tasks enter and leave at a falling edge.
    // ------------------------------------------------------------------
    // Registers sit at byte address 8*index; APB write with setup and access phases.
    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_keys(logic [63:0] in_lo, logic [63:0] in_hi,
                             logic [63:0] out_lo, logic [63:0] out_hi);
        apb_write(REG_WHITEN_IN_LO, in_lo);
        apb_write(REG_WHITEN_IN_HI, in_hi);
        apb_write(REG_WHITEN_OUT_LO, out_lo);
        apb_write(REG_WHITEN_OUT_HI, out_hi);
    endtask

    // Writes to the decoded-but-unused indexes must leave the keys alone
    task automatic poke_unused_regs();
        for (int i = REG_WHITEN_OUT_HI + 1; i < 2**REG_IDX_W; i++)
            apb_write(i[REG_IDX_W-1:0], {$urandom, $urandom});
    endtask

    // Random gap of idle cycles (idle_pct chance per cycle), then hold start
    // until the transaction is taken. start stays high into the next call.
    task automatic send_block(t_in_item blk, int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start  = 1'b1;
        i_item = blk;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Mostly full-range words, with a bias toward the corners
    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(31);
            3:       return ~(32'h1 << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(int unsigned count, int unsigned idle_pct);
        repeat (count)
            send_block(t_in_item'{rand_word(), rand_word(), rand_word(), rand_word()},
                       idle_pct);
        start = 1'b0;
    endtask

    // Keys are read live by the pipeline, so wait for the last result and
    // then the full pipe depth before touching any register.
    task automatic wait_drained();
        while (cipher_sb.expected_blocks.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        t_in_item    blk;
        logic [31:0] corner[6];

        cipher_sb = new();
        corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                   32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset configuration (plain permutation). Same corner
        // value in all words, then one word saturated at a time.
        foreach (corner[i])
            send_block(t_in_item'{corner[i], corner[i], corner[i], corner[i]}, 0);
        for (int j = 0; j < 4; j++) begin
            blk = '0;
            case (j)
                0: blk.word_a = '1;
                1: blk.word_b = '1;
                2: blk.word_c = '1;
                default: blk.word_d = '1;
            endcase
            send_block(blk, 0);
        end
        start = 1'b0;
        wait_drained();

        // Whitening on with the all-zero reset keys: must equal plain output
        apb_write(REG_WHITEN_ENABLE, 64'd1);
        run_random(PHASE_ITEMS, 0);
        wait_drained();

        // All-ones keys; enable written with every bit set, only bit 0 counts.
        // Sender idles 60% of cycles.
        load_keys('1, '1, '1, '1);
        apb_write(REG_WHITEN_ENABLE, '1);
        run_random(PHASE_ITEMS, 60);
        wait_drained();

        // Random keys but whitening off: upper enable bits set, bit 0 clear.
        // Unused register writes thrown in. Back-to-back transactions.
        load_keys({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
        apb_write(REG_WHITEN_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE);
        poke_unused_regs();
        run_random(PHASE_ITEMS, 0);
        wait_drained();

        // Same keys, whitening on again; light sender gaps
        apb_write(REG_WHITEN_ENABLE, 64'h8000_0000_0000_0001);
        run_random(PHASE_ITEMS, 9);
        wait_drained();

        // Fresh random keys, heavy gaps
        load_keys({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
        poke_unused_regs();
        run_random(PHASE_ITEMS, 60);
        wait_drained();

        // Back to reset values written explicitly
        load_keys('0, '0, '0, '0);
        apb_write(REG_WHITEN_ENABLE, 64'd0);
        run_random(PHASE_ITEMS, 0);
        wait_drained();

        if (cipher_sb.mismatches == 0 && cipher_sb.expected_blocks.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/arxpc_pkg.sv
rtl/arxpc_regs.sv
rtl/arxpc_mix_stage.sv
rtl/arx_permutation_cipher_128.sv
tb/tb_arx_permutation_cipher_128.sv
